@@ rtl/lagrange_interpolation_eval_top_defines.svh @@
// assertion macros for the lagrange evaluator
// no dependencies; included by modules that assert
`ifndef LAGRANGE_INTERPOLATION_EVAL_TOP_DEFINES_SVH
`define LAGRANGE_INTERPOLATION_EVAL_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ rtl/lie_pkg.sv @@
// shared types and constants for the lagrange evaluator
// no dependencies
package lie_pkg;
  localparam int MaxNodes = 16;
  localparam int IdxW = $clog2(MaxNodes);
  localparam int CntW = 5;
  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusDup = 2'd1;
  localparam logic [1:0] StatusSat = 2'd2;
  localparam logic signed [31:0] QOne = 32'sd65536;

  // controller commands to the datapath
  typedef struct packed {
    logic start;       // capture query, clear sum and flags
    logic dup_check;   // compare slots i and j
    logic init_l;      // basis factor to one
    logic div_start;   // begin one scale step for slot pair i,j
    logic term;        // accumulate y_i * l_i
    logic finish;      // form the result word
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
  } lie_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic dup_hit;
  } lie_sts_t;
endpackage

@@ rtl/lie_ctrl.sv @@
// sequencer for the lagrange evaluator: duplicate sweep, basis loop, sum
// depends on lie_pkg and the assertion header
`include "lagrange_interpolation_eval_top_defines.svh"
module lie_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic [lie_pkg::CntW-1:0] node_count,
  input  lie_pkg::lie_sts_t sts,
  output lie_pkg::lie_cmd_t cmd,
  output logic busy,
  output logic done
);
  typedef enum logic [2:0] {
    IDLE, DUP, INIT, DIV, WAIT, TERM, SUM, FIN
  } state_t;
  state_t state;
  logic [lie_pkg::IdxW-1:0] i, j, last;
  logic [lie_pkg::IdxW:0] n_eff;

  // clamp node count into 1..MaxNodes
  always_comb begin
    if (node_count == '0) n_eff = (lie_pkg::IdxW+1)'(1);
    else if (node_count > lie_pkg::CntW'(lie_pkg::MaxNodes))
      n_eff = (lie_pkg::IdxW+1)'(lie_pkg::MaxNodes);
    else n_eff = node_count[lie_pkg::IdxW:0];
  end

  // command decode
  always_comb begin
    cmd = '0;
    cmd.i = i;
    cmd.j = j;
    cmd.start = go && state == IDLE;
    cmd.dup_check = state == DUP;
    cmd.init_l = state == INIT;
    cmd.div_start = state == DIV && i != j;
    cmd.term = state == TERM;
    cmd.finish = state == FIN;
  end
  assign busy = state != IDLE;

  // state and counters
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= IDLE;
      i <= '0;
      j <= '0;
      last <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (go) begin
            last <= lie_pkg::IdxW'(n_eff - 1'b1);
            i <= '0;
            j <= lie_pkg::IdxW'(1);
            state <= (n_eff == 1) ? INIT : DUP;
          end
        end
        DUP: begin
          if (sts.dup_hit) state <= FIN;
          else if (j == last) begin
            if (i + 1'b1 == last) begin
              i <= '0;
              state <= INIT;
            end else begin
              i <= i + 1'b1;
              j <= i + 2'd2;
            end
          end else j <= j + 1'b1;
        end
        INIT: begin
          j <= '0;
          state <= DIV;
        end
        DIV: begin
          if (i == j) begin
            if (j == last) state <= TERM;
            else j <= j + 1'b1;
          end else state <= WAIT;
        end
        WAIT: begin
          if (!sts.div_busy) begin
            if (j == last) state <= TERM;
            else begin
              j <= j + 1'b1;
              state <= DIV;
            end
          end
        end
        TERM: begin
          if (i == last) state <= SUM;
          else begin
            i <= i + 1'b1;
            state <= INIT;
          end
        end
        // last term lands in the sum here
        SUM: state <= FIN;
        FIN: begin
          done <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  `ASSERT_NEVER(a_go_idle, clk, rst, go && state != IDLE)
  `ASSERT_IMPL(a_fin_done, clk, rst, state == FIN |=> done)
  `ASSERT_IMPL(a_j_range, clk, rst, (state == DIV) |-> (j <= last))
endmodule

@@ rtl/lie_dpath.sv @@
// datapath: node tables, shared serial divider, term multiply and sum
// depends on lie_pkg and the assertion header
`include "lagrange_interpolation_eval_top_defines.svh"
module lie_dpath (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic [lie_pkg::IdxW-1:0] load_idx,
  input  logic signed [31:0] load_x,
  input  logic signed [31:0] load_y,
  input  logic signed [31:0] query_x,
  input  lie_pkg::lie_cmd_t cmd,
  output lie_pkg::lie_sts_t sts,
  output logic signed [31:0] value,
  output logic [1:0] status
);
  logic signed [31:0] xt [lie_pkg::MaxNodes];
  logic signed [31:0] yt [lie_pkg::MaxNodes];
  logic signed [31:0] qx, l;
  logic signed [65:0] sum;
  logic sat, dup;

  // tables, written by load words
  always_ff @(posedge clk) begin
    if (load) begin
      xt[load_idx] <= load_x;
      yt[load_idx] <= load_y;
    end
  end

  logic signed [32:0] num, den;
  assign num = 33'(signed'(qx)) - 33'(signed'(xt[cmd.j]));
  assign den = 33'(signed'(xt[cmd.i])) - 33'(signed'(xt[cmd.j]));
  assign sts.dup_hit = cmd.dup_check && xt[cmd.i] == xt[cmd.j];

  // serial divider state: magnitude of l*num over magnitude of den
  typedef enum logic [1:0] {D_IDLE, D_MUL, D_RUN, D_END} dstate_t;
  dstate_t dst;
  logic [31:0] ml, mn_lo;
  logic [32:0] mn, md;
  logic [64:0] dividend;
  logic [32:0] rem;
  logic [64:0] quo;
  logic [6:0] cnt;
  logic neg;
  logic [33:0] trial;
  logic [63:0] lm_p;
  assign sts.div_busy = dst != D_IDLE || cmd.div_start;
  assign trial = {rem, dividend[64]} - {1'b0, md};
  assign mn_lo = mn[31:0];
  assign lm_p = ml * mn_lo;

  // term product from registered operand magnitudes
  logic [31:0] ly_a;
  logic [31:0] ly_b;
  logic [63:0] ly_p;
  logic ly_neg, ly_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst <= D_IDLE;
      ly_v <= 1'b0;
    end else begin
      ly_v <= cmd.term;
      case (dst)
        D_IDLE: if (cmd.div_start) begin
          ml <= l[31] ? 32'(-l) : l;
          mn <= num[32] ? 33'(-num) : num;
          md <= den[32] ? 33'(-den) : den;
          neg <= l[31] ^ num[32] ^ den[32];
          dst <= D_MUL;
        end
        D_MUL: begin
          // |l| up to 2^31 and |num| below 2^33: split the product in two
          dividend <= 65'(lm_p) + (mn[32] ? {1'b0, ml, 32'd0} : 65'd0);
          rem <= '0;
          quo <= '0;
          cnt <= 7'd65;
          dst <= D_RUN;
        end
        D_RUN: begin
          if (!trial[33]) rem <= trial[32:0];
          else rem <= {rem[31:0], dividend[64]};
          quo <= {quo[63:0], !trial[33]};
          dividend <= {dividend[63:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == 7'd1) dst <= D_END;
        end
        D_END: dst <= D_IDLE;
        default: dst <= D_IDLE;
      endcase
    end
  end

  // query, basis factor, flags, sum and result word
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx <= query_x;
      sum <= '0;
      sat <= 1'b0;
      dup <= 1'b0;
    end
    if (sts.dup_hit) dup <= 1'b1;
    if (cmd.init_l) l <= lie_pkg::QOne;
    if (dst == D_END) begin
      if (!neg) begin
        if (quo > 65'h7FFFFFFF) begin
          l <= 32'sh7FFFFFFF;
          sat <= 1'b1;
        end else l <= signed'(quo[31:0]);
      end else begin
        if (quo > 65'h80000000) begin
          l <= 32'sh80000000;
          sat <= 1'b1;
        end else l <= signed'(32'(-quo[31:0]));
      end
    end
    if (cmd.term) begin
      ly_a <= l[31] ? 32'(-l) : l;
      ly_b <= yt[cmd.i][31] ? 32'(-yt[cmd.i]) : yt[cmd.i];
      ly_neg <= l[31] ^ yt[cmd.i][31];
    end
    if (ly_v) begin
      if (ly_neg) sum <= sum - 66'(ly_p >> 16);
      else sum <= sum + 66'(ly_p >> 16);
    end
    if (cmd.finish) begin
      if (dup) begin
        value <= '0;
        status <= lie_pkg::StatusDup;
      end else if (sum > 66'sh7FFFFFFF) begin
        value <= 32'sh7FFFFFFF;
        status <= lie_pkg::StatusSat;
      end else if (sum < -66'sh80000000) begin
        value <= 32'sh80000000;
        status <= lie_pkg::StatusSat;
      end else begin
        value <= sum[31:0];
        status <= sat ? lie_pkg::StatusSat : lie_pkg::StatusOk;
      end
    end
  end
  assign ly_p = ly_a * ly_b;

  `ASSERT_NEVER(a_div_restart, clk, rst, cmd.div_start && dst != D_IDLE)
  `ASSERT_IMPL(a_end_idle, clk, rst, dst == D_END |=> dst == D_IDLE)
  `ASSERT_NEVER(a_dup_div, clk, rst, cmd.dup_check && dst != D_IDLE)
endmodule

@@ rtl/lagrange_interpolation_eval_top.sv @@
// Lagrange evaluator in signed Q16.16. A load word (action 0) writes one node
// into the tables. An evaluate word first sweeps the node pairs for equal
// abscissas, one pair a cycle, and ends at the first match; else, for each
// of n nodes, it runs n-1 scale steps through one shared bit-serial divider,
// which takes no new step until it is through with the last one. Result words
// are registered and the block takes the next word once one is taken.
// depends on lie_pkg, lie_ctrl, lie_dpath
module lagrange_interpolation_eval_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [4:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic action,
  input  logic [3:0] node_index,
  input  logic signed [31:0] node_x,
  input  logic signed [31:0] node_y,
  input  logic signed [31:0] query_x,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] value,
  output logic [1:0] status
);
  logic [lie_pkg::CntW-1:0] node_count;
  lie_pkg::lie_cmd_t cmd;
  lie_pkg::lie_sts_t sts;
  logic busy, done, acc, go;

  // node count register
  always_ff @(posedge clk) begin
    if (rst) node_count <= lie_pkg::CntW'(1);
    else if (cfg_we) node_count <= cfg_data;
  end

  assign in_ready = !busy && !out_valid && !done;
  assign acc = in_valid && in_ready;
  assign go = acc && action;

  // result word holding flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  lie_ctrl u_ctrl (
    .clk(clk), .rst(rst), .go(go), .node_count(node_count), .sts(sts),
    .cmd(cmd), .busy(busy), .done(done)
  );

  lie_dpath u_dp (
    .clk(clk), .rst(rst), .load(acc && !action), .load_idx(node_index),
    .load_x(node_x), .load_y(node_y), .query_x(query_x), .cmd(cmd),
    .sts(sts), .value(value), .status(status)
  );
endmodule
